// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the decimal parser RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/dtti_pkg.sv -----
// ---------------------------------------------------------------------------
// dtti_pkg
// Types and constants shared by the decimal text parser modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtti_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ValueW = 32;

  localparam logic [CharW-1:0]  CharZero  = 8'd48;
  localparam logic [CharW-1:0]  CharNine  = 8'd57;
  localparam logic [CharW-1:0]  CharPlus  = 8'd43;
  localparam logic [CharW-1:0]  CharMinus = 8'd45;
  localparam logic [CharW-1:0]  CharNul   = 8'd0;

  // One tenth of the largest magnitude, and the last-digit limits
  localparam logic [ValueW-1:0] LimitTenth = 32'd214748364;
  localparam logic [3:0]        TopPos     = 4'd7;
  localparam logic [3:0]        TopNeg     = 4'd8;
  localparam logic [ValueW-1:0] MaxMag     = 32'h8000_0000;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_DIGITS = 2'd1,
    PH_TAIL   = 2'd2,
    PH_REJECT = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_PREFIX = 2'd1,
    ST_NO_DIGITS  = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_e;

  typedef struct packed {
    phase_e            phase;
    logic              minus;
    logic [ValueW-1:0] acc;
    status_e           err;
  } parse_state_t;

  localparam parse_state_t StateReset = '{
    phase: PH_PREFIX,
    minus: 1'b0,
    acc:   '0,
    err:   ST_OK
  };

endpackage

// ----- rtl/dtti_step.sv -----
// ---------------------------------------------------------------------------
// dtti_step
// Next-state and result logic for one byte of the parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtti_step (
  input  dtti_pkg::parse_state_t          state_i,
  input  logic [dtti_pkg::CharW-1:0]      char_code_i,
  output dtti_pkg::parse_state_t          state_o,
  output logic [dtti_pkg::ValueW-1:0]     value_o,
  output dtti_pkg::status_e               status_o
);

  logic                          is_digit;
  logic [dtti_pkg::CharW-1:0]    digit_wide;
  logic [3:0]                    digit;
  logic [3:0]                    top;
  logic                          ovf;
  logic [dtti_pkg::ValueW-1:0]   acc_next;

  assign is_digit   = (char_code_i >= dtti_pkg::CharZero) &&
                      (char_code_i <= dtti_pkg::CharNine);
  assign digit_wide = char_code_i - dtti_pkg::CharZero;
  assign digit      = digit_wide[3:0];
  assign top        = state_i.minus ? dtti_pkg::TopNeg : dtti_pkg::TopPos;
  assign ovf        = (state_i.acc > dtti_pkg::LimitTenth) ||
                      ((state_i.acc == dtti_pkg::LimitTenth) && (digit > top));
  // acc * 10 + digit as two shifts and adds
  assign acc_next   = (state_i.acc << 3) + (state_i.acc << 1) +
                      {{(dtti_pkg::ValueW-4){1'b0}}, digit};

  always_comb begin
    state_o  = state_i;
    value_o  = '0;
    status_o = dtti_pkg::ST_OK;
    if (char_code_i == dtti_pkg::CharNul) begin
      state_o = dtti_pkg::StateReset;
      unique case (state_i.phase)
        dtti_pkg::PH_PREFIX: status_o = dtti_pkg::ST_NO_DIGITS;
        dtti_pkg::PH_REJECT: status_o = state_i.err;
        default: begin
          value_o = state_i.minus ? (dtti_pkg::ValueW'(0) - state_i.acc) : state_i.acc;
        end
      endcase
    end else begin
      unique case (state_i.phase)
        dtti_pkg::PH_PREFIX: begin
          if (is_digit) begin
            if (ovf) begin
              state_o.phase = dtti_pkg::PH_REJECT;
              state_o.err   = dtti_pkg::ST_OVERFLOW;
            end else begin
              state_o.phase = dtti_pkg::PH_DIGITS;
              state_o.acc   = acc_next;
            end
          end else if (char_code_i == dtti_pkg::CharMinus) begin
            state_o.minus = ~state_i.minus;
          end else if (char_code_i != dtti_pkg::CharPlus) begin
            state_o.phase = dtti_pkg::PH_REJECT;
            state_o.err   = dtti_pkg::ST_BAD_PREFIX;
          end
        end
        dtti_pkg::PH_DIGITS: begin
          if (!is_digit) begin
            state_o.phase = dtti_pkg::PH_TAIL;
          end else if (ovf) begin
            state_o.phase = dtti_pkg::PH_REJECT;
            state_o.err   = dtti_pkg::ST_OVERFLOW;
          end else begin
            state_o.acc = acc_next;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/dtti_out_reg.sv -----
// ---------------------------------------------------------------------------
// dtti_out_reg
// Result register with valid/stall handshake toward the consumer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtti_out_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [dtti_pkg::ValueW-1:0]   value_i,
  input  dtti_pkg::status_e             status_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [dtti_pkg::ValueW-1:0]   value_o,
  output logic [1:0]                    status_o
);

  logic                        valid_q, valid_d;
  logic [dtti_pkg::ValueW-1:0] value_q;
  logic [1:0]                  status_q;

  // load_i only arrives when the register is empty or draining
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_q  <= value_i;
      status_q <= status_i;
    end
  end

  assign out_valid_o = valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

// ----- rtl/decimal_text_to_int32.sv -----
// Output: a result appears in the cycle after its terminating zero byte transfers.
// Throughput: one byte per cycle; the per-byte update (multiply by ten, limit
//   compare) sits between the parse state register and the result register.
// A zero byte waits only while the previous result is still held by a stall;
//   other bytes keep flowing. Reset clears parse state and the result valid.
// ---------------------------------------------------------------------------
// decimal_text_to_int32
// Byte-stream decimal parser producing a signed 32-bit value and a status.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module decimal_text_to_int32 (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           char_code_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   value_o,
  output logic [1:0]           status_o
);

  // Parse state: phase, sign parity, magnitude and sticky error.
  dtti_pkg::parse_state_t       state_q, state_d;
  logic [dtti_pkg::ValueW-1:0]  res_value;
  dtti_pkg::status_e            res_status;
  logic                         is_end;
  logic                         in_xfer;
  logic [dtti_pkg::ValueW-1:0]  out_value;

  assign is_end  = (char_code_i == dtti_pkg::CharNul);

  // Only the terminating byte needs room in the result register. Ordinary
  // bytes just update the parse state, so they never wait on the consumer.
  assign in_stall_o = is_end && out_valid_o && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  dtti_step u_step (
    .state_i     (state_q),
    .char_code_i (char_code_i),
    .state_o     (state_d),
    .value_o     (res_value),
    .status_o    (res_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtti_pkg::StateReset;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Result register; loads on the transfer of a zero byte.
  dtti_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_xfer && is_end),
    .value_i     (res_value),
    .status_i    (res_status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .value_o     (out_value),
    .status_o    (status_o)
  );

  assign value_o = $signed(out_value);

  // Magnitude never exceeds 2^31 (the largest negative value).
  `ASSERT_ALWAYS(a_acc_bound, clk_i, rst_ni, state_q.acc <= dtti_pkg::MaxMag)
  // A rejected or empty string always reports zero.
  `ASSERT_SAME(a_zero_on_err, clk_i, rst_ni, out_valid_o && (status_o != dtti_pkg::ST_OK), value_o == 32'sd0)
  // A transferred zero byte yields a result and restarts parsing.
  `ASSERT_NEXT(a_end_result, clk_i, rst_ni, in_xfer && is_end, out_valid_o && (state_q.phase == dtti_pkg::PH_PREFIX))
  // Error code is only non-ok in the rejected phase.
  `ASSERT_SAME(a_err_phase, clk_i, rst_ni, state_q.err != dtti_pkg::ST_OK, state_q.phase == dtti_pkg::PH_REJECT)

endmodule
